FILE: hdl/ppmfg_pkg.sv
// ============================================================================
// PPM frame generator package
// Shared widths, register map, operation codes and payload types.
// ============================================================================
`default_nettype none

package ppmfg_pkg;

    // Channel store geometry
    localparam int MAX_CHANNELS = 16;
    localparam int CH_AW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 5;
    localparam int STORE_W = 11;
    localparam int FRAME_W = 16;
    localparam int PULSE_W = 10;
    localparam int COUNT_W = 5;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_FRAME_LENGTH  = 3'd0;
    localparam logic [2:0] REG_PULSE_LENGTH  = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_INVERT_OUTPUT = 3'd3;
    localparam logic [2:0] REG_SCALE_MIN     = 3'd4;
    localparam logic [2:0] REG_SCALE_MAX     = 3'd5;

    // Register reset values
    localparam logic [FRAME_W-1:0] FRAME_LENGTH_RST  = 16'd22500;
    localparam logic [PULSE_W-1:0] PULSE_LENGTH_RST  = 10'd300;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 5'd8;
    localparam logic               INVERT_OUTPUT_RST = 1'b0;
    localparam logic [STORE_W-1:0] SCALE_MIN_RST     = 11'd1000;
    localparam logic [STORE_W-1:0] SCALE_MAX_RST     = 11'd2000;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_SCALED = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_DIRECT = 2'd2;

    // Scaling arithmetic
    localparam logic [VALUE_W-1:0] SCALE_LO  = 16'd1000;
    localparam logic [STORE_W-1:0] STORE_MAX = 11'd2047;
    localparam int PROD_W      = 27;   // |value-1000| * |max-min| < 2^27
    localparam int QUOT_W      = 18;   // quotient by 1000 < 2^18
    localparam int RECIP_SHIFT = 36;
    localparam logic [PROD_W-1:0] RECIP_MULT = PROD_W'((64'd1 << RECIP_SHIFT) / 1000);
    localparam logic [PROD_W:0]   DIV_CONST  = 28'd1000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } ppmfg_item_t;

    typedef struct packed {
        logic              pin_level;
        logic [SLOT_W-1:0] slot_index;
    } ppmfg_result_t;

endpackage

`default_nettype wire

FILE: hdl/ppmfg_ram.sv
// ============================================================================
// PPM frame generator RAM
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
`default_nettype none

module ppmfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/ppm_frame_generator.sv
// ============================================================================
// PPM frame generator
// Builds an RC pulse-position frame from microsecond tick transactions.
// ============================================================================
//
// Usage:
//   item channel   : valid/ready. op selects a tick, a scaled channel write
//                    or a direct channel write. Every transaction produces
//                    exactly one result transaction.
//   result channel : valid/ready. pin_level is the line level after the item,
//                    slot_index the slot on air (channel count = sync gap).
//   APB port       : six registers at byte offsets 0x00..0x14; write them
//                    only while no transaction is in flight.
//   Path           : item acceptance to result valid runs through the
//                    scaled-write divide (product, reciprocal multiply,
//                    remainder correction) followed by the commit stage,
//                    which reads the channel store at the next slot counter.
//   Throughput     : one transaction per clock, sustained while result_ready stays high.
//   Reset          : counters cleared, line at idle level, store reads zero;
//                    the first tick starts a marker pulse.
//   Stall          : a held result does not block input while pipeline
//                    stages are free; the stages fill, then item_ready drops.
// ============================================================================
`default_nettype none

module ppm_frame_generator
    import ppmfg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    // item channel
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire ppmfg_item_t         item,
    // result channel
    output logic                     result_valid,
    input  wire logic                result_ready,
    output ppmfg_result_t            result
);

    localparam logic [SLOT_W-1:0] MAX_SLOT = SLOT_W'(MAX_CHANNELS);
    localparam int SUM_W = QUOT_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FRAME_W-1:0] frame_length_reg;
    logic [PULSE_W-1:0] pulse_length_reg;
    logic [COUNT_W-1:0] channel_count_reg;
    logic               invert_output_reg;
    logic [STORE_W-1:0] scale_min_reg;
    logic [STORE_W-1:0] scale_max_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg  <= FRAME_LENGTH_RST;
            pulse_length_reg  <= PULSE_LENGTH_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
            invert_output_reg <= INVERT_OUTPUT_RST;
            scale_min_reg     <= SCALE_MIN_RST;
            scale_max_reg     <= SCALE_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_LENGTH:  frame_length_reg  <= pwdata[FRAME_W-1:0];
                REG_PULSE_LENGTH:  pulse_length_reg  <= pwdata[PULSE_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[COUNT_W-1:0];
                REG_INVERT_OUTPUT: invert_output_reg <= pwdata[0];
                REG_SCALE_MIN:     scale_min_reg     <= pwdata[STORE_W-1:0];
                REG_SCALE_MAX:     scale_max_reg     <= pwdata[STORE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_FRAME_LENGTH:  prdata = PDATA_W'(frame_length_reg);
            REG_PULSE_LENGTH:  prdata = PDATA_W'(pulse_length_reg);
            REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_reg);
            REG_INVERT_OUTPUT: prdata = PDATA_W'(invert_output_reg);
            REG_SCALE_MIN:     prdata = PDATA_W'(scale_min_reg);
            REG_SCALE_MAX:     prdata = PDATA_W'(scale_max_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage advances when the one after it has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic result_valid_reg;
    logic out_free, s4_free, s3_free, s2_free, s1_free;
    logic s4_commit;

    assign out_free   = !result_valid_reg || result_ready;
    assign s4_free    = !s4_valid_reg || out_free;
    assign s3_free    = !s3_valid_reg || s4_free;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign s4_commit  = s4_valid_reg && out_free;
    assign item_ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)  s1_valid_reg     <= item_valid;
            if (s2_free)  s2_valid_reg     <= s1_valid_reg;
            if (s3_free)  s3_valid_reg     <= s2_valid_reg;
            if (s4_free)  s4_valid_reg     <= s3_valid_reg;
            if (out_free) result_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitude product |value - 1000| * |max - min|
    // ------------------------------------------------------------------
    logic               d_neg, r_neg;
    logic [VALUE_W-1:0] d_abs;
    logic [STORE_W-1:0] r_abs;
    logic [STORE_W-1:0] direct_w;

    assign d_neg    = item.value < SCALE_LO;
    assign d_abs    = d_neg ? (SCALE_LO - item.value) : (item.value - SCALE_LO);
    assign r_neg    = scale_max_reg < scale_min_reg;
    assign r_abs    = r_neg ? (scale_min_reg - scale_max_reg)
                            : (scale_max_reg - scale_min_reg);
    // direct writes saturate at the top of the store range
    assign direct_w = (item.value > VALUE_W'(STORE_MAX)) ? STORE_MAX
                                                        : item.value[STORE_W-1:0];

    logic [OP_W-1:0]    s1_op_reg,      s2_op_reg,      s3_op_reg,      s4_op_reg;
    logic [CHAN_W-1:0]  s1_channel_reg, s2_channel_reg, s3_channel_reg, s4_channel_reg;
    logic [STORE_W-1:0] s1_direct_reg,  s2_direct_reg,  s3_direct_reg,  s4_direct_reg;
    logic               s1_neg_reg,     s2_neg_reg,     s3_neg_reg,     s4_neg_reg;
    logic [PROD_W-1:0]  s1_prod_reg,    s2_prod_reg;
    logic [QUOT_W-1:0]  s2_quot0_reg;
    logic [QUOT_W-1:0]  s3_quot_reg;
    logic [QUOT_W-1:0]  s4_quot_reg;

    always_ff @(posedge clk)
    begin
        if (item_valid && s1_free)
        begin
            s1_op_reg      <= item.op;
            s1_channel_reg <= item.channel;
            s1_direct_reg  <= direct_w;
            s1_neg_reg     <= d_neg ^ r_neg;
            s1_prod_reg    <= PROD_W'(d_abs) * PROD_W'(r_abs);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient estimate by reciprocal multiply (low by at most one)
    // ------------------------------------------------------------------
    logic [2*PROD_W-1:0] recip_prod;

    assign recip_prod = (2*PROD_W)'(s1_prod_reg) * (2*PROD_W)'(RECIP_MULT);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_free)
        begin
            s2_op_reg      <= s1_op_reg;
            s2_channel_reg <= s1_channel_reg;
            s2_direct_reg  <= s1_direct_reg;
            s2_neg_reg     <= s1_neg_reg;
            s2_prod_reg    <= s1_prod_reg;
            s2_quot0_reg   <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: remainder check, bump the quotient when it reaches 1000
    // ------------------------------------------------------------------
    logic [PROD_W:0]   quot_times;
    logic [PROD_W:0]   remainder;
    logic [QUOT_W-1:0] quot_fixed;

    // 1000 = 1024 - 16 - 8
    assign quot_times = ((PROD_W+1)'(s2_quot0_reg) << 10)
                      - ((PROD_W+1)'(s2_quot0_reg) << 4)
                      - ((PROD_W+1)'(s2_quot0_reg) << 3);
    assign remainder  = (PROD_W+1)'(s2_prod_reg) - quot_times;
    assign quot_fixed = (remainder >= DIV_CONST) ? (s2_quot0_reg + QUOT_W'(1))
                                                 : s2_quot0_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            s3_op_reg      <= s2_op_reg;
            s3_channel_reg <= s2_channel_reg;
            s3_direct_reg  <= s2_direct_reg;
            s3_neg_reg     <= s2_neg_reg;
            s3_quot_reg    <= quot_fixed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s4_free)
        begin
            s4_op_reg      <= s3_op_reg;
            s4_channel_reg <= s3_channel_reg;
            s4_direct_reg  <= s3_direct_reg;
            s4_neg_reg     <= s3_neg_reg;
            s4_quot_reg    <= s3_quot_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed offset, clamp, and the store write
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] scaled_sum;
    logic [STORE_W-1:0]      scaled_w;

    // truncation toward zero: apply the sign after the unsigned divide
    assign scaled_sum = s4_neg_reg ? (SUM_W'(scale_min_reg) - SUM_W'(s4_quot_reg))
                                   : (SUM_W'(scale_min_reg) + SUM_W'(s4_quot_reg));

    always_comb
    begin
        if (scaled_sum < 0)
        begin
            scaled_w = '0;
        end
        else if (scaled_sum > SUM_W'(STORE_MAX))
        begin
            scaled_w = STORE_MAX;
        end
        else
        begin
            scaled_w = scaled_sum[STORE_W-1:0];
        end
    end

    logic               store_we;
    logic [CH_AW-1:0]   store_waddr;
    logic [STORE_W-1:0] store_wdata;
    logic [CH_AW-1:0]   store_raddr;
    logic [STORE_W-1:0] store_rdata;
    logic [STORE_W-1:0] store_word;

    logic [MAX_CHANNELS-1:0] entry_valid_reg;
    logic                    fwd_hit_reg;
    logic [STORE_W-1:0]      fwd_data_reg;

    // drop writes to channels the store does not hold
    assign store_we    = s4_commit
                      && (s4_op_reg == OP_SET_SCALED || s4_op_reg == OP_SET_DIRECT)
                      && (32'(s4_channel_reg) < MAX_CHANNELS);
    assign store_waddr = CH_AW'(s4_channel_reg);
    assign store_wdata = (s4_op_reg == OP_SET_SCALED) ? scaled_w : s4_direct_reg;

    // ------------------------------------------------------------------
    // Frame timing state
    // ------------------------------------------------------------------
    logic [FRAME_W-1:0] wait_counter_reg, wait_counter_next;
    logic               in_gap_reg,       in_gap_next;
    logic [SLOT_W-1:0]  slot_counter_reg, slot_counter_next;
    logic [FRAME_W-1:0] frame_sum_reg,    frame_sum_next;
    logic               line_level_reg,   line_level_next;

    // The store is read ahead, through its registered port, at the next slot counter. A write to
    // that same entry in the same cycle is forwarded; unwritten entries read 0.
    assign store_raddr = CH_AW'(slot_counter_next);
    assign store_word  = fwd_hit_reg ? fwd_data_reg
                       : (entry_valid_reg[CH_AW'(slot_counter_reg)] ? store_rdata
                                                                    : '0);

    ppmfg_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            if (store_we)
            begin
                entry_valid_reg[store_waddr] <= 1'b1;
            end
            fwd_hit_reg <= store_we && (store_waddr == store_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= store_wdata;
    end

    logic [SLOT_W-1:0]  eff_count;
    logic [FRAME_W-1:0] pulse_wait;
    logic [FRAME_W:0]   sum_pulse;
    logic [FRAME_W-1:0] used_sync;
    logic [FRAME_W-1:0] sync_wait;
    logic [FRAME_W-1:0] slot_wait;
    logic [FRAME_W:0]   sum_slot;
    logic [FRAME_W-1:0] sum_slot_sat;

    assign eff_count  = (SLOT_W'(channel_count_reg) > MAX_SLOT) ? MAX_SLOT
                                                                : SLOT_W'(channel_count_reg);
    // a zero-length pulse still lasts one tick
    assign pulse_wait = (pulse_length_reg == '0) ? '0
                                                 : FRAME_W'(pulse_length_reg) - FRAME_W'(1);
    assign sum_pulse  = (FRAME_W+1)'(frame_sum_reg) + (FRAME_W+1)'(pulse_length_reg);
    assign used_sync  = sum_pulse[FRAME_W] ? '1 : sum_pulse[FRAME_W-1:0];
    // sync gap fills the rest of the frame, at least one tick
    assign sync_wait  = (used_sync >= frame_length_reg) ? '0
                                                        : frame_length_reg - used_sync
                                                          - FRAME_W'(1);
    // a slot not longer than the pulse gets a one-tick gap
    assign slot_wait  = (store_word > STORE_W'(pulse_length_reg))
                      ? FRAME_W'(store_word) - FRAME_W'(pulse_length_reg) - FRAME_W'(1)
                      : '0;
    assign sum_slot     = (FRAME_W+1)'(frame_sum_reg) + (FRAME_W+1)'(store_word);
    assign sum_slot_sat = sum_slot[FRAME_W] ? '1 : sum_slot[FRAME_W-1:0];

    always_comb
    begin
        wait_counter_next = wait_counter_reg;
        in_gap_next       = in_gap_reg;
        slot_counter_next = slot_counter_reg;
        frame_sum_next    = frame_sum_reg;
        line_level_next   = line_level_reg;

        if (s4_commit && s4_op_reg == OP_TICK)
        begin
            if (wait_counter_reg != '0)
            begin
                wait_counter_next = wait_counter_reg - FRAME_W'(1);
            end
            else if (!in_gap_reg)
            begin
                // start a marker pulse
                line_level_next   = invert_output_reg;
                wait_counter_next = pulse_wait;
                in_gap_next       = 1'b1;
            end
            else
            begin
                line_level_next = !invert_output_reg;
                in_gap_next     = 1'b0;
                if (slot_counter_reg >= eff_count)
                begin
                    // sync gap closes the frame
                    slot_counter_next = '0;
                    wait_counter_next = sync_wait;
                    frame_sum_next    = '0;
                end
                else
                begin
                    wait_counter_next = slot_wait;
                    frame_sum_next    = sum_slot_sat;
                    slot_counter_next = slot_counter_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_counter_reg <= '0;
            in_gap_reg       <= 1'b0;
            slot_counter_reg <= '0;
            frame_sum_reg    <= '0;
            line_level_reg   <= !INVERT_OUTPUT_RST;
        end
        else
        begin
            wait_counter_reg <= wait_counter_next;
            in_gap_reg       <= in_gap_next;
            slot_counter_reg <= slot_counter_next;
            frame_sum_reg    <= frame_sum_next;
            line_level_reg   <= line_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] slot_index_next;
    ppmfg_result_t     result_reg;

    always_comb
    begin
        if (in_gap_next)
        begin
            slot_index_next = slot_counter_next;
        end
        else if (slot_counter_next == '0)
        begin
            slot_index_next = eff_count;
        end
        else
        begin
            slot_index_next = slot_counter_next - SLOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_commit)
        begin
            result_reg.pin_level  <= line_level_next;
            result_reg.slot_index <= slot_index_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_counter_reg <= MAX_SLOT)
        else $error("slot counter ran past the channel store");

    a_store_marked: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |=> entry_valid_reg[$past(store_waddr)])
        else $error("written store entry not marked valid");

    a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_commit && s4_op_reg == OP_TICK && wait_counter_reg != '0)
        |=> (wait_counter_reg == $past(wait_counter_reg) - FRAME_W'(1)))
        else $error("wait counter did not count down on a tick");

    a_set_holds_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_commit && s4_op_reg != OP_TICK)
        |=> ($stable(wait_counter_reg) && $stable(slot_counter_reg)
             && $stable(in_gap_reg)))
        else $error("non-tick transaction moved frame timing");

endmodule

`default_nettype wire
